@@ hw/rtl/lbpvar_pkg.sv @@
// ----------------------------------------------------------------------------
// lbpvar_pkg
// Shared types, constants and sample-forming helpers of the local variance
// filter.
// ----------------------------------------------------------------------------
package lbpvar_pkg;

  localparam int PIX_W  = 8;
  localparam int SAMP_W = 16;   // Q8 circle sample, max 65280
  localparam int VAR_W  = 19;   // variance, Q4
  localparam int NUM_W  = 38;   // 8*S2 - S1^2
  localparam int X_W    = 23;   // numerator with 15 low bits dropped
  localparam int DROP_BITS = 15; // 56*4096 = 7 * 2^15

  // Bilinear weights of a diagonal point, Q8, sum to 256
  localparam logic [7:0] W_CORNER = 8'd128;
  localparam logic [7:0] W_EDGE   = 8'd53;
  localparam logic [7:0] W_CENTRE = 8'd22;

  // x/7 by reciprocal: floor(2^26/7), then one correction step
  localparam int          DIV7_SHIFT = 26;
  localparam logic [23:0] DIV7_MUL   = 24'd9586980;
  localparam logic [23:0] DIVISOR    = 24'd7;

  // Configuration register indexes
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  // 3x3 window, [row][col]; row 0 is the oldest line, col 2 the newest pixel
  typedef logic [2:0][2:0][PIX_W-1:0] lbpvar_win_t;

  typedef struct packed {
    logic valid;
    logic row_end;
    logic frame_end;
  } lbpvar_tag_t;

  function automatic logic [SAMP_W-1:0] axis_sample(input logic [PIX_W-1:0] p);
    return {p, 8'h00};
  endfunction

  function automatic logic [SAMP_W-1:0] diag_sample(input logic [PIX_W-1:0] corner,
                                                   input logic [PIX_W-1:0] e1,
                                                   input logic [PIX_W-1:0] e2,
                                                   input logic [PIX_W-1:0] ctr);
    logic [16:0] acc;
    acc = 17'(corner) * 17'(W_CORNER)
        + (17'(e1) + 17'(e2)) * 17'(W_EDGE)
        + 17'(ctr) * 17'(W_CENTRE);
    return acc[SAMP_W-1:0];
  endfunction

endpackage

@@ hw/rtl/lbpvar_line_mem.sv @@
// ----------------------------------------------------------------------------
// lbpvar_line_mem
// Two-line pixel store: one entry per column holds {row r-2, row r-1}.
// One read port with registered data, one write port.
// ----------------------------------------------------------------------------
module lbpvar_line_mem import lbpvar_pkg::*; #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic               clk,
  input  logic               rd_en,
  input  logic [AW-1:0]      rd_addr,
  output logic [2*PIX_W-1:0] rd_data,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  logic [2*PIX_W-1:0] wr_data
);

  logic [2*PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data only moves on a read, so it holds across stalls
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hw/rtl/lbpvar_variance.sv @@
// ----------------------------------------------------------------------------
// lbpvar_variance
// Seven-stage pipeline: circle samples, squares, sums, numerator, and an
// exact divide by 7*2^15 via reciprocal multiply and one correction.
// ----------------------------------------------------------------------------
module lbpvar_variance import lbpvar_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  lbpvar_win_t       win,
  input  lbpvar_tag_t       tag_in,
  output lbpvar_tag_t       tag_out,
  output logic [VAR_W-1:0]  variance
);

  lbpvar_tag_t tag0, tag1, tag2, tag3, tag4, tag5;

  logic [SAMP_W-1:0] samp [8];
  logic [31:0]       sq1  [8];
  logic [16:0]       p1   [4];
  logic [32:0]       q2   [4];
  logic [18:0]       s1_2;
  logic [34:0]       s2_3;
  logic [NUM_W-1:0]  s1sq_3;
  logic [X_W-1:0]    x4, x5;
  logic [46:0]       prod5;

  logic [NUM_W-1:0]  num;
  logic [20:0]       q0;
  logic [23:0]       rem;
  logic [20:0]       quot;

  always_comb begin
    num  = {s2_3, 3'b000};
    q0   = prod5[46:DIV7_SHIFT];
    rem  = 24'(x5) - 24'(q0) * DIVISOR;
    quot = (rem >= DIVISOR) ? q0 + 21'd1 : q0;
  end

  // tags
  always_ff @(posedge clk) begin
    if (rst) begin
      tag0    <= '0;
      tag1    <= '0;
      tag2    <= '0;
      tag3    <= '0;
      tag4    <= '0;
      tag5    <= '0;
      tag_out <= '0;
    end else if (en) begin
      tag0    <= tag_in;
      tag1    <= tag0;
      tag2    <= tag1;
      tag3    <= tag2;
      tag4    <= tag3;
      tag5    <= tag4;
      tag_out <= tag5;
    end
  end

  // data path
  always_ff @(posedge clk) begin
    if (en) begin
      // stage 0: circle samples, counterclockwise from the right
      samp[0] <= axis_sample(win[1][2]);
      samp[1] <= diag_sample(win[0][2], win[0][1], win[1][2], win[1][1]);
      samp[2] <= axis_sample(win[0][1]);
      samp[3] <= diag_sample(win[0][0], win[0][1], win[1][0], win[1][1]);
      samp[4] <= axis_sample(win[1][0]);
      samp[5] <= diag_sample(win[2][0], win[1][0], win[2][1], win[1][1]);
      samp[6] <= axis_sample(win[2][1]);
      samp[7] <= diag_sample(win[2][2], win[2][1], win[1][2], win[1][1]);

      // stage 1: squares, pair sums
      for (int k = 0; k < 8; k++) begin
        sq1[k] <= 32'(samp[k]) * 32'(samp[k]);
      end
      for (int j = 0; j < 4; j++) begin
        p1[j] <= 17'(samp[2*j]) + 17'(samp[2*j+1]);
      end

      // stage 2: pair sums of squares, S1
      for (int j = 0; j < 4; j++) begin
        q2[j] <= 33'(sq1[2*j]) + 33'(sq1[2*j+1]);
      end
      s1_2 <= 19'(p1[0]) + 19'(p1[1]) + 19'(p1[2]) + 19'(p1[3]);

      // stage 3: S2, S1^2
      s2_3   <= (35'(q2[0]) + 35'(q2[1])) + (35'(q2[2]) + 35'(q2[3]));
      s1sq_3 <= NUM_W'(s1_2) * NUM_W'(s1_2);

      // stage 4: numerator, drop the power-of-two part of the divisor
      if (num >= s1sq_3) begin
        x4 <= X_W'((num - s1sq_3) >> DROP_BITS);
      end else begin
        x4 <= '0;
      end

      // stage 5: reciprocal multiply
      prod5 <= 47'(x4) * 47'(DIV7_MUL);
      x5    <= x4;

      // stage 6: estimate is low by at most one
      variance <= quot[VAR_W-1:0];
    end
  end

endmodule

@@ hw/rtl/lbp_local_variance_filter_core.sv @@
// ----------------------------------------------------------------------------
// lbp_local_variance_filter_core
// Rotation-invariant local variance over the 8-point radius-1 circle.
// ----------------------------------------------------------------------------
// Pixels enter one per beat in raster order and the block sustains one pixel
// per clock unless out_stall holds it: a two-line store (one 16-bit entry
// per column, read as the pixel is taken and written back from the stage-1
// register) feeds a 3x3 window, and a 7-stage arithmetic pipeline turns each
// window into a result. Only interior pixels
// (not on the first/last row or column) give a result, so the result for the
// pixel one row up and one column left of the newest pixel is emitted; border
// pixels produce nothing. The four axis samples are pixel*256, the four
// diagonal samples are bilinear with Q8 weights 128/53/53/22. The output is
// (8*S2 - S1^2)/56 with 4 fractional bits, truncated. row_end marks the last
// result of a row, frame_end the last result of a frame. The whole pipeline
// holds while out_stall is high with a result waiting; in_stall follows.
// image_width (reg 0) is clamped to 3..MAX_WIDTH, image_height (reg 1) to a
// minimum of 3. Write configuration only while the block is empty. The line
// store has no reset and needs no clearing pass: the first two rows of a
// frame only fill it. No ready wait on configuration writes.
// ----------------------------------------------------------------------------
module lbp_local_variance_filter_core import lbpvar_pkg::*; #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic              clk,
  input  logic              rst,

  input  logic              in_valid,
  output logic              in_stall,
  input  logic [PIX_W-1:0]  pixel,

  output logic              out_valid,
  input  logic              out_stall,
  output logic [VAR_W-1:0]  variance_q4,
  output logic              row_end,
  output logic              frame_end,

  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [15:0]       cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);  // column / line store address
  localparam int WW = CW + 1;             // holds the width itself

  // configuration
  logic [11:0] image_width;
  logic [15:0] image_height;

  // counters (position of the next pixel)
  logic [CW-1:0] col_cnt;
  logic [15:0]   row_cnt;

  // stage 1: pixel waiting for its line store data
  logic              s1_valid;
  logic [PIX_W-1:0]  s1_px;
  logic [CW-1:0]     s1_col;
  lbpvar_tag_t       s1_tag;

  lbpvar_win_t win, win_next;

  logic [2*PIX_W-1:0] rd_data;
  logic               advance, in_accept;

  logic [WW-1:0]  eff_w;
  logic [15:0]    eff_h;
  logic           col_wrap;
  logic [CW-1:0]  c;
  logic [16:0]    row_pre;
  logic [15:0]    r;
  logic [WW-1:0]  c_inc;
  logic [16:0]    r_inc;
  logic [CW-1:0]  col_next;
  logic [15:0]    row_next;
  lbpvar_tag_t    tag_next;
  lbpvar_tag_t    var_tag_in, var_tag_out;

  assign cfg_ready = 1'b1;

  // whole pipeline moves together; output stage is the last pipeline stage
  assign advance   = !var_tag_out.valid || !out_stall;
  assign in_stall  = !advance;
  assign in_accept = in_valid && advance;

  // effective frame size
  always_comb begin
    if (image_width < 12'd3) begin
      eff_w = WW'(3);
    end else if (32'(image_width) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(image_width);
    end
    eff_h = (image_height < 16'd3) ? 16'd3 : image_height;
  end

  // position of this pixel, with wrap if the size shrank since the last one
  always_comb begin
    col_wrap = {1'b0, col_cnt} >= eff_w;
    c        = col_wrap ? '0 : col_cnt;
    row_pre  = col_wrap ? 17'(row_cnt) + 17'd1 : 17'(row_cnt);
    r        = (row_pre >= {1'b0, eff_h}) ? 16'd0 : row_pre[15:0];

    c_inc = {1'b0, c} + WW'(1);
    r_inc = 17'(r) + 17'd1;
    if (c_inc >= eff_w) begin
      col_next = '0;
      row_next = (r_inc >= {1'b0, eff_h}) ? 16'd0 : r_inc[15:0];
    end else begin
      col_next = c_inc[CW-1:0];
      row_next = r;
    end

    tag_next.valid     = (r >= 16'd2) && (c >= CW'(2));
    tag_next.row_end   = (c_inc == eff_w);
    tag_next.frame_end = (c_inc == eff_w) && (r_inc == {1'b0, eff_h});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 12'd640;
      image_height <= 16'd480;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[11:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt  <= '0;
      row_cnt  <= '0;
      s1_valid <= 1'b0;
      s1_tag   <= '0;
    end else if (advance) begin
      s1_valid <= in_accept;
      if (in_accept) begin
        col_cnt <= col_next;
        row_cnt <= row_next;
        s1_tag  <= tag_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_px  <= pixel;
      s1_col <= c;
    end
  end

  // line store: read at accept, write {row r-1, this row} back from the stage-1
  // register as it advances. Consecutive pixels never share a column, so no forwarding.
  lbpvar_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (in_accept),
    .rd_addr (c),
    .rd_data (rd_data),
    .wr_en   (s1_valid && advance),
    .wr_addr (s1_col),
    .wr_data ({rd_data[PIX_W-1:0], s1_px})
  );

  // window shift left, new column = {row r-2, row r-1, this pixel}
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      win_next[k][0] = win[k][1];
      win_next[k][1] = win[k][2];
    end
    win_next[0][2] = rd_data[2*PIX_W-1:PIX_W];
    win_next[1][2] = rd_data[PIX_W-1:0];
    win_next[2][2] = s1_px;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (s1_valid && advance) begin
      win <= win_next;
    end
  end

  always_comb begin
    var_tag_in       = s1_tag;
    var_tag_in.valid = s1_valid && s1_tag.valid;
  end

  lbpvar_variance u_variance (
    .clk      (clk),
    .rst      (rst),
    .en       (advance),
    .win      (win_next),
    .tag_in   (var_tag_in),
    .tag_out  (var_tag_out),
    .variance (variance_q4)
  );

  assign out_valid = var_tag_out.valid;
  assign row_end   = var_tag_out.row_end;
  assign frame_end = var_tag_out.frame_end;

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LBP local variance filter core. Pixels stream
// in raster order under random input gaps and output back-pressure. A
// scoreboard mirrors the line stores, the 3x3 window and the row and column
// counters, and predicts the variance, row_end and frame_end of each result
// beat. Frames run under many geometry settings, the clamped ones among them,
// and the geometry is also changed part-way through a frame.
// ----------------------------------------------------------------------------
module tb_top import lbpvar_pkg::*; ();

  localparam int MAX_W         = 2048;
  localparam int PREFILL_W     = 128;      // covers every column the later frames reach
  localparam int SETTLE_CYCLES = 16;       // covers the stage-1 register and the variance pipeline
  localparam int LONG_HOLD     = 400;      // receiver hold-off, in cycles
  localparam int RANDOM_ITEMS  = 1250;
  localparam int FIRST_HOLD_AT  = 60;      // early in the prefill frame
  localparam int SECOND_HOLD_AT = 1000;    // inside the random frames
  localparam longint TIME_LIMIT = 64'd50_000_000;

  typedef struct packed {
    logic [VAR_W-1:0] variance;
    logic             row_end;
    logic             frame_end;
  } var_result_t;

  typedef enum {STYLE_UNIFORM, STYLE_EXTREME, STYLE_SMOOTH} pixel_style_t;
  typedef enum {SHIFT_WIDTH, SHIFT_HEIGHT, TALL_FRAME, WIDE_ROW} midframe_kind_t;

  // Directed frames. First: 3x3 of extremes, centre 0 and axis points 255.
  localparam logic [PIX_W-1:0] CROSS_3X3 [9] = '{
    8'd0,   8'd255, 8'd0,
    8'd255, 8'd0,   8'd255,
    8'd0,   8'd255, 8'd0
  };
  // Second: 4x3, first window flat (zero variance), second one carries a spike.
  localparam logic [PIX_W-1:0] SPIKE_4X3 [12] = '{
    8'd7, 8'd7, 8'd7, 8'd7,
    8'd7, 8'd7, 8'd7, 8'd200,
    8'd7, 8'd7, 8'd7, 8'd7
  };

  // --------------------------------------------------------------------------
  // Scoreboard: mirror of the filter state and queue of expected result beats
  // --------------------------------------------------------------------------
  class variance_scoreboard;
    logic [PIX_W-1:0] last_line  [MAX_W];   // previous row, by column
    logic [PIX_W-1:0] older_line [MAX_W];   // row before that
    lbpvar_win_t      win;
    int unsigned      col;
    int unsigned      row;
    logic [11:0]      width_reg;
    logic [15:0]      height_reg;
    var_result_t      expected [$];
    int               failures;

    function new();
      for (int i = 0; i < MAX_W; i++) begin
        last_line[i]  = '0;
        older_line[i] = '0;
      end
      win        = '0;
      col        = 0;
      row        = 0;
      width_reg  = 12'd640;
      height_reg = 16'd480;
      failures   = 0;
    endfunction

    function int unsigned eff_width();
      if (width_reg < 3) return 3;
      if (width_reg > MAX_W) return MAX_W;
      return width_reg;
    endfunction

    function int unsigned eff_height();
      return (height_reg < 3) ? 3 : height_reg;
    endfunction

    function void write_reg(logic idx, logic [15:0] data);
      if (idx == REG_IMAGE_WIDTH) begin
        width_reg = data[11:0];
      end else begin
        height_reg = data;
      end
    endfunction

    // Q8 bilinear point: corner 128, each adjacent axis pixel 53, centre 22
    function longint unsigned diag_point(logic [PIX_W-1:0] corner, logic [PIX_W-1:0] e1,
                                         logic [PIX_W-1:0] e2, logic [PIX_W-1:0] ctr);
      return 128 * longint'(corner) + 53 * (longint'(e1) + longint'(e2))
           + 22 * longint'(ctr);
    endfunction

    // Exact (8*S2 - S1^2) / 56 on Q8 samples, kept at Q4, truncated
    function logic [VAR_W-1:0] circle_variance();
      longint unsigned pts [8];
      longint unsigned s1;
      longint unsigned s2;
      longint unsigned num;
      longint unsigned sq;
      pts[0] = longint'(win[1][2]) * 256;
      pts[1] = diag_point(win[0][2], win[0][1], win[1][2], win[1][1]);
      pts[2] = longint'(win[0][1]) * 256;
      pts[3] = diag_point(win[0][0], win[0][1], win[1][0], win[1][1]);
      pts[4] = longint'(win[1][0]) * 256;
      pts[5] = diag_point(win[2][0], win[1][0], win[2][1], win[1][1]);
      pts[6] = longint'(win[2][1]) * 256;
      pts[7] = diag_point(win[2][2], win[2][1], win[1][2], win[1][1]);
      s1 = 0;
      s2 = 0;
      for (int k = 0; k < 8; k++) begin
        s1 += pts[k];
        s2 += pts[k] * pts[k];
      end
      num = 8 * s2;
      sq  = s1 * s1;
      num = (num >= sq) ? num - sq : 0;
      return VAR_W'(num / (56 * 4096));
    endfunction

    // Accepted pixel beat: advance the mirror, queue a result for interior pixels
    function void note_pixel(logic [PIX_W-1:0] px);
      int unsigned w;
      int unsigned h;
      int unsigned c;
      int unsigned r;
      logic [PIX_W-1:0] up1;
      logic [PIX_W-1:0] up2;
      var_result_t res;
      w = eff_width();
      h = eff_height();
      // counters may sit past a geometry that shrank mid-frame
      if (col >= w) begin
        col = 0;
        row++;
      end
      if (row >= h) row = 0;
      c = col;
      r = row;
      up2 = older_line[c];
      up1 = last_line[c];
      older_line[c] = up1;
      last_line[c]  = px;
      for (int k = 0; k < 3; k++) begin
        win[k][0] = win[k][1];
        win[k][1] = win[k][2];
      end
      win[0][2] = up2;
      win[1][2] = up1;
      win[2][2] = px;
      if (r >= 2 && c >= 2) begin
        res.variance  = circle_variance();
        res.row_end   = (c == w - 1);
        res.frame_end = (c == w - 1) && (r == h - 1);
        expected.push_back(res);
      end
      col = c + 1;
      if (col >= w) begin
        col = 0;
        row = r + 1;
        if (row >= h) row = 0;
      end
    endfunction

    function void report_failure(string what, var_result_t want, var_result_t got);
      failures++;
      if (failures <= 10) begin
        $display("ERROR %s: expected var=%0d re=%0b fe=%0b, got var=%0d re=%0b fe=%0b",
                 what, want.variance, want.row_end, want.frame_end,
                 got.variance, got.row_end, got.frame_end);
      end
    endfunction

    function void check_result(logic [VAR_W-1:0] v, logic re, logic fe);
      var_result_t got;
      var_result_t want;
      got = '{variance: v, row_end: re, frame_end: fe};
      if (expected.size() == 0) begin
        report_failure("result beat with nothing outstanding", '0, got);
      end else begin
        want = expected.pop_front();
        if (got !== want) report_failure("result mismatch", want, got);
      end
    endfunction

    function bit at_frame_start();
      return (col == 0) && (row == 0);
    endfunction

    function int pending();
      return expected.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT and its signals
  // --------------------------------------------------------------------------
  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic [PIX_W-1:0]  pixel;
  logic              out_valid;
  logic              out_stall;
  logic [VAR_W-1:0]  variance_q4;
  logic              row_end;
  logic              frame_end;
  logic              cfg_valid;
  logic              cfg_ready;
  logic              cfg_index;
  logic [15:0]       cfg_data;

  lbp_local_variance_filter_core #(.MAX_WIDTH(MAX_W)) dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .pixel       (pixel),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .variance_q4 (variance_q4),
    .row_end     (row_end),
    .frame_end   (frame_end),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  variance_scoreboard sb = new();

  // Stimulus knobs shared by the driver tasks
  bit           hold_req      = 1'b0;   // main thread asks, receiver counts it out
  bit           steady_feed   = 1'b0;   // no input gaps while set
  pixel_style_t pix_style     = STYLE_UNIFORM;
  int           smooth_base   = 0;
  int           pixels_sent   = 0;
  int           next_hold_at  = FIRST_HOLD_AT;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #(TIME_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall pattern, quiet stretches, and the long hold-off
  // that backs the pipeline up into in_stall.
  // --------------------------------------------------------------------------
  initial begin
    int pick;
    int free_len;
    int stall_len;
    out_stall <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end
      pick = $urandom_range(0, 99);
      if (pick < 50) free_len = $urandom_range(1, 4);
      else if (pick < 85) free_len = $urandom_range(5, 20);
      else free_len = $urandom_range(60, 250);   // stretch with no stalls
      out_stall <= 1'b0;
      repeat (free_len) @(posedge clk);
      pick = $urandom_range(0, 99);
      if (pick < 75) stall_len = $urandom_range(1, 2);
      else if (pick < 95) stall_len = $urandom_range(3, 8);
      else stall_len = $urandom_range(15, 40);
      out_stall <= 1'b1;
      repeat (stall_len) @(posedge clk);
    end
  end

  // Result beats: sampled at the edge, before any update of that edge lands
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(variance_q4, row_end, frame_end);
  end

  // --------------------------------------------------------------------------
  // Driver tasks
  // --------------------------------------------------------------------------
  function automatic int gap_len();
    int pick;
    if (steady_feed) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 70) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [PIX_W-1:0] next_pixel();
    int v;
    case (pix_style)
      STYLE_EXTREME: v = ($urandom_range(0, 1) != 0) ? 255 : 0;
      STYLE_SMOOTH: begin
        v = smooth_base + int'($urandom_range(0, 6)) - 3;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
      end
      default: v = $urandom_range(0, 255);
    endcase
    return PIX_W'(v);
  endfunction

  // Per-frame feel: content style and whether the feed runs without gaps
  function automatic void pick_frame_feel();
    pix_style   = pixel_style_t'($urandom_range(0, 2));
    smooth_base = $urandom_range(0, 255);
    steady_feed = ($urandom_range(0, 3) == 0);
  endfunction

  // Width write: mostly small, some below 3, some with junk above bit 11
  function automatic logic [15:0] pick_width();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) return 16'($urandom_range(0, 2));
    if (pick < 85) return 16'($urandom_range(3, 24));
    if (pick < 97) return 16'($urandom_range(25, 64));
    return 16'hF000 | 16'($urandom_range(3, 20));
  endfunction

  function automatic logic [15:0] pick_height();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) return 16'($urandom_range(0, 2));
    if (pick < 90) return 16'($urandom_range(3, 8));
    return 16'($urandom_range(9, 16));
  endfunction

  task automatic send_pixel(input logic [PIX_W-1:0] p);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel    <= p;
    do @(posedge clk); while (in_stall);
    sb.note_pixel(p);
    pixels_sent++;
    if (pixels_sent == next_hold_at) begin
      hold_req = 1'b1;
      next_hold_at = (next_hold_at == FIRST_HOLD_AT) ? SECOND_HOLD_AT : -1;
    end
  endtask

  task automatic send_run(input int n);
    repeat (n) send_pixel(next_pixel());
  endtask

  // Block is empty once every result is in and border pixels have drained
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_beat(input logic idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  task automatic set_geometry(input bit set_w, input logic [15:0] w,
                              input bit set_h, input logic [15:0] h);
    wait_idle();
    if (set_w) cfg_beat(REG_IMAGE_WIDTH, w);
    if (set_h) cfg_beat(REG_IMAGE_HEIGHT, h);
    cfg_valid <= 1'b0;
  endtask

  // Geometry change part-way through a frame. Every line-store column these
  // can reach was filled by the prefill frame before any of them run.
  task automatic change_mid_frame();
    case (midframe_kind_t'($urandom_range(0, 3)))
      SHIFT_WIDTH:  set_geometry(1'b1, pick_width(), 1'b0, 16'd0);
      SHIFT_HEIGHT: set_geometry(1'b0, 16'd0, 1'b1, pick_height());
      TALL_FRAME: begin
        // tallest frame for a few rows, then cut back: row may land past the end
        set_geometry(1'b0, 16'd0, 1'b1, 16'hFFFF);
        send_run($urandom_range(1, 3) * sb.eff_width());
        set_geometry(1'b0, 16'd0, 1'b1, pick_height());
      end
      default: begin
        // width 4095 clamps to the widest row for a short stretch, then
        // narrow: column lands past the end
        set_geometry(1'b1, 16'hFFFF, 1'b0, 16'd0);
        send_run($urandom_range(20, 60));
        set_geometry(1'b1, pick_width(), 1'b0, 16'd0);
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int start_count;
    int frames;
    int span;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    pixel     <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data  <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: width below 3 acts as 3, one window of pure extremes
    steady_feed = 1'b1;
    set_geometry(1'b1, 16'd2, 1'b1, 16'd3);
    for (int i = 0; i < 9; i++) send_pixel(CROSS_3X3[i]);

    // Width with bits above the register, height below 3: a 4x3 frame with a
    // flat window followed by a spiked one that ends the row and the frame
    set_geometry(1'b1, 16'h1004, 1'b1, 16'd2);
    for (int i = 0; i < 12; i++) send_pixel(SPIKE_4X3[i]);

    // Prefill frame: height 0 acts as 3. Fills every line-store column the
    // later frames can reach. First long hold-off lands here.
    steady_feed = 1'b0;
    pix_style   = STYLE_UNIFORM;
    set_geometry(1'b1, 16'(PREFILL_W), 1'b1, 16'h0000);
    send_run(3 * PREFILL_W);

    // Random frames under random geometry, some disturbed mid-frame
    start_count = pixels_sent;
    while (pixels_sent - start_count < RANDOM_ITEMS) begin
      set_geometry(1'b1, pick_width(), $urandom_range(0, 4) != 0, pick_height());
      frames = $urandom_range(1, 2);
      repeat (frames) begin
        pick_frame_feel();
        if ($urandom_range(0, 4) == 0) begin
          span = sb.eff_width() * sb.eff_height();
          send_run($urandom_range(1, span - 1));
          change_mid_frame();
        end
        do send_pixel(next_pixel()); while (!sb.at_frame_start());
      end
    end

    wait_idle();
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
